// ===== design/sac_pkg.sv =====
// Shared types and codes for the segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package sac_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_RANGE = 3'd1,
      ST_IN_USE   = 3'd2,
      ST_UNKNOWN  = 3'd3,
      ST_FULL     = 3'd4,
      ST_ZERO     = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      CMD_CREATE = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_SEG_RD,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_APPLY,
      S_WR_HIT,
      S_WR_SLOT,
      S_DONE
   } state_type;

   // Request to the compare unit: which compare the sequencer wants.
   typedef enum logic [1:0] {
      CMP_CONTAIN,
      CMP_BEFORE,
      CMP_AFTER
   } cmp_op_type;

   typedef struct packed {
      logic contain;
      logic start_eq;
      logic end_eq;
   } cmp_res_type;

endpackage
`default_nettype wire

// ===== design/sac_cmp.sv =====
// Compare unit: range containment and adjacency tests on one free entry.
`timescale 1ns / 1ps
`default_nettype none
module sac_cmp #(
   parameter int ADDR_BITS = 16
) (
   input  wire logic [ADDR_BITS-1:0] ent_start,
   input  wire logic [ADDR_BITS-1:0] ent_length,
   input  wire logic [ADDR_BITS-1:0] key_start,
   input  wire logic [ADDR_BITS-1:0] key_length,
   output sac_pkg::cmp_res_type      res
);
   logic [ADDR_BITS:0] ent_end;
   logic [ADDR_BITS:0] key_end;

   always_comb begin
      ent_end      = {1'b0, ent_start} + {1'b0, ent_length};
      key_end      = {1'b0, key_start} + {1'b0, key_length};
      res.contain  = (ent_start <= key_start) && (key_end <= ent_end);
      res.start_eq = (ent_start == key_start);
      res.end_eq   = (ent_end == key_end);
   end
endmodule
`default_nettype wire

// ===== design/segment_allocator_coalescing.sv =====
// Top level: sequenced segment allocator with coalescing free ranges.
//
// Usage:
//  - req_ beats carry one create or remove command; rsp_ returns one status
//    beat per request, in order.
//  - csr_ writes the address-space size; only while idle. The write clears
//    both tables by a sweep over the FREE_SLOTS free entries (during which no
//    request is taken). Reset runs the same sweep with total size 65535.
//  - A request walks the free table entry by entry through two compare
//    units: an id-read step, then a read step and a compare step per entry.
//    The same walk finds the containing range, both merge neighbors and the
//    first empty slot. Then S_APPLY decides, S_WR_HIT and S_WR_SLOT write, and
//    S_DONE raises the status.
//  - rsp_tvalid rises once S_DONE is left; the next request is taken only
//    after the status beat has been taken.
//  - The status stays in the output register until rsp_tready; req_tready
//    stays low until it is taken.
//  - Free table and segment table are register arrays read by index.
`timescale 1ns / 1ps
`default_nettype none
module segment_allocator_coalescing #(
   parameter int FREE_SLOTS  = 16,
   parameter int SEGMENT_IDS = 16,
   parameter int ADDR_BITS   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: command[0], segment_id[4:1], start_req[20:5], size[36:21], pad
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: status[2:0], pad
   output logic [7:0]       rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   localparam int FW = $clog2(FREE_SLOTS);
   localparam int SW = (SEGMENT_IDS > 1) ? $clog2(SEGMENT_IDS) : 1;
   localparam logic [ADDR_BITS:0] AMAX = {1'b0, {ADDR_BITS{1'b1}}};
   // reset size: 65535, clamped to the address width
   localparam logic [ADDR_BITS-1:0] TOTAL_RST = (ADDR_BITS >= 16) ?
      ADDR_BITS'(17'h0FFFF) : AMAX[ADDR_BITS-1:0];

   // Free table and segment table.
   logic [ADDR_BITS-1:0] fs_ff [FREE_SLOTS];
   logic [ADDR_BITS-1:0] fl_ff [FREE_SLOTS];
   logic [FREE_SLOTS-1:0] fv_ff;
   logic [ADDR_BITS-1:0] sb_ff [SEGMENT_IDS];
   logic [ADDR_BITS-1:0] sl_ff [SEGMENT_IDS];
   logic [SEGMENT_IDS-1:0] sv_ff;

   sac_pkg::state_type st_ff, st_in;
   logic [ADDR_BITS-1:0] total_ff;
   logic [FW:0] idx_ff, idx_in;
   logic cmd_ff;
   logic [3:0] id_ff;
   logic [ADDR_BITS-1:0] kst_ff, klen_ff;
   logic [2:0] status_ff;
   logic rsp_valid_ff;
   // scan results
   logic hit_ok_ff, bef_ok_ff, aft_ok_ff, slot_ok_ff;
   logic [FW-1:0] hit_ff, bef_ff, aft_ff, slot_ff;
   logic hs_eq_ff, he_eq_ff;
   // registered entry read
   logic [ADDR_BITS-1:0] rs_ff, rl_ff;
   logic rv_ff;
   logic [ADDR_BITS-1:0] hs_ff, hl_ff, bl_ff, al_ff;

   sac_pkg::cmp_res_type cr_c, cr_a;
   logic [ADDR_BITS:0] kend;
   logic id_range;

   assign kend = {1'b0, kst_ff} + {1'b0, klen_ff};
   assign id_range = ({28'd0, id_ff} < SEGMENT_IDS);

   // Containment test against key; after-test uses end as start.
   sac_cmp #(.ADDR_BITS(ADDR_BITS)) u_cmp (
      .ent_start(rs_ff), .ent_length(rl_ff),
      .key_start(kst_ff), .key_length(klen_ff), .res(cr_c));
   sac_cmp #(.ADDR_BITS(ADDR_BITS)) u_cmpa (
      .ent_start(rs_ff), .ent_length({ADDR_BITS{1'b0}}),
      .key_start(kend[ADDR_BITS-1:0]), .key_length({ADDR_BITS{1'b0}}), .res(cr_a));

   logic [ADDR_BITS:0] r_end;
   assign r_end = {1'b0, rs_ff} + {1'b0, rl_ff};
   logic bef_m, aft_m;
   assign bef_m = rv_ff && (r_end == {1'b0, kst_ff});
   assign aft_m = rv_ff && !kend[ADDR_BITS] && cr_a.start_eq;

   // next state
   always_comb begin
      st_in  = st_ff;
      idx_in = idx_ff;
      case (st_ff)
         sac_pkg::S_IDLE: begin
            idx_in = '0;
            if (csr_valid) st_in = sac_pkg::S_INIT;
            else if (req_tvalid && !rsp_valid_ff) st_in = sac_pkg::S_SEG_RD;
         end
         sac_pkg::S_INIT: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (FW+1)'(FREE_SLOTS - 1)) st_in = sac_pkg::S_IDLE;
         end
         sac_pkg::S_SEG_RD: begin
            idx_in = '0;
            st_in  = sac_pkg::S_SCAN_RD;
         end
         sac_pkg::S_SCAN_RD: st_in = sac_pkg::S_SCAN_CMP;
         sac_pkg::S_SCAN_CMP: begin
            idx_in = idx_ff + 1'b1;
            st_in  = (idx_ff == (FW+1)'(FREE_SLOTS - 1)) ? sac_pkg::S_APPLY
                                                          : sac_pkg::S_SCAN_RD;
         end
         sac_pkg::S_APPLY:   st_in = sac_pkg::S_WR_HIT;
         sac_pkg::S_WR_HIT:  st_in = sac_pkg::S_WR_SLOT;
         sac_pkg::S_WR_SLOT: st_in = sac_pkg::S_DONE;
         sac_pkg::S_DONE:    st_in = sac_pkg::S_IDLE;
         default:            st_in = sac_pkg::S_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = (st_ff == sac_pkg::S_IDLE) && !csr_valid && !rsp_valid_ff;
      csr_ready  = (st_ff == sac_pkg::S_IDLE);
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {5'd0, status_ff};
   end

   // error code decided once the scan is done
   logic [2:0] dec_status;
   logic need_slot;
   always_comb begin
      need_slot  = 1'b0;
      dec_status = sac_pkg::ST_OK;
      if (cmd_ff == sac_pkg::CMD_CREATE) begin
         need_slot = hit_ok_ff && !hs_eq_ff && !he_eq_ff;
         if (klen_ff == '0) dec_status = sac_pkg::ST_ZERO;
         else if (!id_range) dec_status = sac_pkg::ST_UNKNOWN;
         else if (sv_ff[id_ff[SW-1:0]]) dec_status = sac_pkg::ST_IN_USE;
         else if (!hit_ok_ff) dec_status = sac_pkg::ST_NO_RANGE;
         else if (need_slot && !slot_ok_ff) dec_status = sac_pkg::ST_FULL;
      end else begin
         need_slot = !bef_ok_ff && !aft_ok_ff;
         if (!id_range || !sv_ff[id_ff[SW-1:0]]) dec_status = sac_pkg::ST_UNKNOWN;
         else if (need_slot && !slot_ok_ff) dec_status = sac_pkg::ST_FULL;
      end
   end

   logic [ADDR_BITS-1:0] csr_clamp;
   assign csr_clamp = (33'(csr_data) > 33'(AMAX)) ? AMAX[ADDR_BITS-1:0]
                                                  : ADDR_BITS'(csr_data);
   logic [FW-1:0] ix;
   assign ix = idx_ff[FW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= sac_pkg::S_INIT;
         idx_ff       <= '0;
         total_ff     <= TOTAL_RST;
         rsp_valid_ff <= 1'b0;
         fv_ff        <= '0;
         sv_ff        <= '0;
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (st_ff)
            sac_pkg::S_IDLE: begin
               if (csr_valid) begin
                  total_ff <= csr_clamp;
               end else if (req_tvalid && !rsp_valid_ff) begin
                  cmd_ff  <= req_tdata[0];
                  id_ff   <= req_tdata[4:1];
                  kst_ff  <= ADDR_BITS'(req_tdata[20:5]);
                  klen_ff <= ADDR_BITS'(req_tdata[36:21]);
               end
            end
            sac_pkg::S_INIT: begin
               fs_ff[ix] <= '0;
               fl_ff[ix] <= total_ff;
               fv_ff[ix] <= (ix == '0) && (total_ff != '0);
               sv_ff     <= '0;
            end
            sac_pkg::S_SEG_RD: begin
               hit_ok_ff <= 1'b0; bef_ok_ff <= 1'b0;
               aft_ok_ff <= 1'b0; slot_ok_ff <= 1'b0;
               if (cmd_ff == sac_pkg::CMD_REMOVE && id_range) begin
                  kst_ff  <= sb_ff[id_ff[SW-1:0]];
                  klen_ff <= sl_ff[id_ff[SW-1:0]];
               end
            end
            sac_pkg::S_SCAN_RD: begin
               rs_ff <= fs_ff[ix];
               rl_ff <= fl_ff[ix];
               rv_ff <= fv_ff[ix];
            end
            sac_pkg::S_SCAN_CMP: begin
               if (!rv_ff && !slot_ok_ff) begin
                  slot_ok_ff <= 1'b1; slot_ff <= ix;
               end
               if (rv_ff && cr_c.contain && !hit_ok_ff) begin
                  hit_ok_ff <= 1'b1; hit_ff <= ix;
                  hs_eq_ff <= cr_c.start_eq; he_eq_ff <= cr_c.end_eq;
                  hs_ff <= rs_ff; hl_ff <= rl_ff;
               end
               if (bef_m && !bef_ok_ff) begin
                  bef_ok_ff <= 1'b1; bef_ff <= ix; bl_ff <= rl_ff;
               end
               if (aft_m && !aft_ok_ff) begin
                  aft_ok_ff <= 1'b1; aft_ff <= ix; al_ff <= rl_ff;
               end
            end
            sac_pkg::S_APPLY: begin
               status_ff <= dec_status;
            end
            sac_pkg::S_WR_HIT: begin
               if (status_ff == sac_pkg::ST_OK) begin
                  if (cmd_ff == sac_pkg::CMD_CREATE) begin
                     sb_ff[id_ff[SW-1:0]] <= kst_ff;
                     sl_ff[id_ff[SW-1:0]] <= klen_ff;
                     sv_ff[id_ff[SW-1:0]] <= 1'b1;
                     if (hs_eq_ff && he_eq_ff) fv_ff[hit_ff] <= 1'b0;
                     else if (hs_eq_ff) begin
                        fs_ff[hit_ff] <= kend[ADDR_BITS-1:0];
                        fl_ff[hit_ff] <= ADDR_BITS'(({1'b0, hs_ff} + {1'b0, hl_ff}) - kend);
                     end else
                        fl_ff[hit_ff] <= kst_ff - hs_ff;
                  end else begin
                     sv_ff[id_ff[SW-1:0]] <= 1'b0;
                     if (bef_ok_ff) begin
                        fl_ff[bef_ff] <= bl_ff + klen_ff + (aft_ok_ff ? al_ff : '0);
                        if (aft_ok_ff) fv_ff[aft_ff] <= 1'b0;
                     end else if (aft_ok_ff) begin
                        fs_ff[aft_ff] <= kst_ff;
                        fl_ff[aft_ff] <= al_ff + klen_ff;
                     end
                  end
               end
            end
            sac_pkg::S_WR_SLOT: begin
               if (status_ff == sac_pkg::ST_OK) begin
                  if (cmd_ff == sac_pkg::CMD_CREATE && !hs_eq_ff && !he_eq_ff) begin
                     fs_ff[slot_ff] <= kend[ADDR_BITS-1:0];
                     fl_ff[slot_ff] <= ADDR_BITS'(({1'b0, hs_ff} + {1'b0, hl_ff}) - kend);
                     fv_ff[slot_ff] <= 1'b1;
                  end else if (cmd_ff == sac_pkg::CMD_REMOVE && !bef_ok_ff && !aft_ok_ff) begin
                     fs_ff[slot_ff] <= kst_ff;
                     fl_ff[slot_ff] <= klen_ff;
                     fv_ff[slot_ff] <= 1'b1;
                  end
               end
            end
            sac_pkg::S_DONE: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // A result is raised only at the end of a request.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(st_ff == sac_pkg::S_DONE)) else $error("rsp w/o done");
   // No request is taken while a status is still held.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("overlap");
   // Status code is always a defined one.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= 3'd5)) else $error("bad status");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the segment allocator: directed and random create/remove traffic checked by a table model.
`timescale 1ns / 1ps
`default_nettype none
module tb;

   // Allocation table model; keeps expected statuses in order.
   class alloc_board;
      logic [15:0] total;
      logic [15:0] fr_start[16];
      logic [15:0] fr_len[16];
      bit          fr_ok[16];
      logic [15:0] sg_base[16];
      logic [15:0] sg_len[16];
      bit          sg_ok[16];
      sac_pkg::status_type pending[$];
      int          errors;

      function void clear_tables(logic [15:0] sz);
         total = sz;
         foreach (fr_ok[i]) begin
            fr_ok[i] = 0;
            sg_ok[i] = 0;
         end
         fr_start[0] = 0;
         fr_len[0]   = sz;
         fr_ok[0]    = (sz != 0);
      endfunction

      function int open_slot();
         for (int i = 0; i < 16; i++)
            if (!fr_ok[i]) return i;
         return -1;
      endfunction

      function sac_pkg::status_type create_seg(logic [3:0] id, logic [16:0] st,
                                               logic [16:0] sz);
         int hit;
         int slot;
         logic [16:0] fs, fe, en;
         hit = -1;
         en = st + sz;
         if (sz == 0) return sac_pkg::ST_ZERO;
         if (sg_ok[id]) return sac_pkg::ST_IN_USE;
         for (int i = 0; i < 16; i++) begin
            if (fr_ok[i] && hit < 0) begin
               fs = fr_start[i];
               fe = fs + fr_len[i];
               if (fs <= st && en <= fe) hit = i;
            end
         end
         if (hit < 0) return sac_pkg::ST_NO_RANGE;
         fs = fr_start[hit];
         fe = fs + fr_len[hit];
         if (fs == st && fe == en) fr_ok[hit] = 0;
         else if (fs == st) begin
            fr_start[hit] = en[15:0];
            fr_len[hit]   = 16'(fe - en);
         end else if (fe == en) fr_len[hit] = 16'(st - fs);
         else begin
            slot = open_slot();
            if (slot < 0) return sac_pkg::ST_FULL;
            fr_len[hit]    = 16'(st - fs);
            fr_start[slot] = en[15:0];
            fr_len[slot]   = 16'(fe - en);
            fr_ok[slot]    = 1;
         end
         sg_base[id] = st[15:0];
         sg_len[id]  = sz[15:0];
         sg_ok[id]   = 1;
         return sac_pkg::ST_OK;
      endfunction

      function sac_pkg::status_type remove_seg(logic [3:0] id);
         int lo, hi, slot;
         logic [16:0] b, l;
         lo = -1;
         hi = -1;
         if (!sg_ok[id]) return sac_pkg::ST_UNKNOWN;
         b = sg_base[id];
         l = sg_len[id];
         for (int i = 0; i < 16; i++) begin
            if (fr_ok[i]) begin
               if (lo < 0 && 17'(fr_start[i]) + fr_len[i] == b) lo = i;
               if (hi < 0 && 17'(fr_start[i]) == b + l) hi = i;
            end
         end
         if (lo >= 0 && hi >= 0) begin
            fr_len[lo] = 16'(fr_len[lo] + l + fr_len[hi]);
            fr_ok[hi]  = 0;
         end else if (lo >= 0) fr_len[lo] = 16'(fr_len[lo] + l);
         else if (hi >= 0) begin
            fr_start[hi] = b[15:0];
            fr_len[hi]   = 16'(fr_len[hi] + l);
         end else begin
            slot = open_slot();
            if (slot < 0) return sac_pkg::ST_FULL;
            fr_start[slot] = b[15:0];
            fr_len[slot]   = l[15:0];
            fr_ok[slot]    = 1;
         end
         sg_ok[id] = 0;
         return sac_pkg::ST_OK;
      endfunction

      function void note_request(logic [39:0] d);
         if (sac_pkg::command_type'(d[0]) == sac_pkg::CMD_CREATE)
            pending.push_back(create_seg(d[4:1], {1'b0, d[20:5]}, {1'b0, d[36:21]}));
         else
            pending.push_back(remove_seg(d[4:1]));
      endfunction

      function void check_status(logic [7:0] d);
         sac_pkg::status_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected status beat %0d", $time, d[2:0]);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (d[2:0] !== want) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, want, d[2:0]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, rsp_tready = 0, csr_valid = 0;
   logic [39:0] req_tdata = 0;
   logic [15:0] csr_data = 0;
   wire req_tready, rsp_tvalid, csr_ready;
   wire [7:0] rsp_tdata;
   alloc_board board;
   bit hold_rsp = 0;   // long receiver stall, set by the stimulus process

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   segment_allocator_coalescing u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Receiver: random stalls, with a long hold when asked.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_status(rsp_tdata);
   end
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 0;
            for (int i = 0; i < 400; i++) @(posedge clock);
            hold_rsp = 0;
         end
         g = gap_len();
         if (g == 0) rsp_tready <= 1;
         else begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
            rsp_tready <= 1;
         end
      end
   end

   // Always puts a gap after the previous beat, so valid drops cleanly.
   task automatic send_req(logic cmd, logic [3:0] id, logic [15:0] st, logic [15:0] sz);
      int g;
      g = gap_len();
      repeat (g + 1) @(posedge clock);
      req_tvalid <= 1;
      req_tdata  <= {3'b0, sz, st, id, cmd};
      do @(posedge clock); while (!req_tready);
      board.note_request({3'b0, sz, st, id, cmd});
      req_tvalid <= 0;
   endtask

   // Waits until the model drains, then the block's own settle time, then writes.
   task automatic write_size(logic [15:0] v);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_valid <= 1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      board.clear_tables(v);
      csr_valid <= 0;
   endtask

   // Mostly well-formed: creates starting inside the space, removes of random ids.
   task automatic random_phase(int n, logic [15:0] space);
      logic [15:0] st, sz;
      logic [3:0] id;
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         id = 4'($urandom_range(0, 15));
         if (r < 50) begin
            st = (space > 1) ? 16'($urandom_range(0, space - 1)) : 16'd0;
            sz = 16'($urandom_range(1, (space > 8) ? space / 8 : 2));
            send_req(sac_pkg::CMD_CREATE, id, st, sz);
         end else if (r < 85)
            send_req(sac_pkg::CMD_REMOVE, id, 16'($urandom), 16'($urandom));
         else
            send_req(1'($urandom_range(0, 1)), id, 16'($urandom),
                     ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
      end
   endtask

   initial begin
      board = new();
      board.clear_tables(16'hFFFF);
      repeat (9) @(posedge clock);
      reset <= 0;
      repeat (40) @(posedge clock);
      // Directed: zero size, unknown id, id in use, no range, all split shapes, merges.
      send_req(sac_pkg::CMD_CREATE, 0, 0, 0);
      send_req(sac_pkg::CMD_REMOVE, 15, 0, 0);
      send_req(sac_pkg::CMD_CREATE, 15, 16'hFFFF, 16'hFFFF);
      send_req(sac_pkg::CMD_CREATE, 1, 0, 100);
      send_req(sac_pkg::CMD_CREATE, 1, 200, 10);
      send_req(sac_pkg::CMD_CREATE, 2, 16'hFFFE, 1);
      send_req(sac_pkg::CMD_CREATE, 3, 300, 50);
      send_req(sac_pkg::CMD_CREATE, 4, 100, 200);
      send_req(sac_pkg::CMD_REMOVE, 4, 0, 0);
      send_req(sac_pkg::CMD_REMOVE, 1, 0, 0);
      send_req(sac_pkg::CMD_REMOVE, 3, 0, 0);
      send_req(sac_pkg::CMD_REMOVE, 2, 0, 0);
      send_req(sac_pkg::CMD_REMOVE, 2, 0, 0);
      for (int i = 0; i < 12; i++)
         send_req(sac_pkg::CMD_CREATE, 4'(i), 16'(i * 10 + 5), 2);
      write_size(16'd0);
      send_req(sac_pkg::CMD_CREATE, 0, 0, 1);
      send_req(sac_pkg::CMD_CREATE, 0, 0, 0);
      write_size(16'd1);
      send_req(sac_pkg::CMD_CREATE, 0, 0, 1);
      send_req(sac_pkg::CMD_CREATE, 1, 0, 1);
      send_req(sac_pkg::CMD_REMOVE, 0, 0, 0);
      // Pressure: receiver stalls while requests keep coming.
      hold_rsp = 1;
      write_size(16'd64);
      random_phase(300, 64);
      write_size(16'd4096);
      hold_rsp = 1;
      random_phase(400, 4096);
      write_size(16'hFFFF);
      random_phase(400, 16'hFFFF);
      write_size(16'd40);
      random_phase(300, 40);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0) $display("segment_allocator_coalescing test passed");
      else $display("segment_allocator_coalescing test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("segment_allocator_coalescing test failed");
      $finish;
   end
endmodule
`default_nettype wire
